>>> src/scan_plane_pixel_shader_defines.svh
// ============================================================================
// Scan plane pixel shader assertion macros
// Shared property shapes for the checker of the scan plane pixel shader.
// ============================================================================
`ifndef SCAN_PLANE_PIXEL_SHADER_DEFINES_SVH
`define SCAN_PLANE_PIXEL_SHADER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SPPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SPPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spps_pkg.sv
// ============================================================================
// Scan plane pixel shader package
// Beat types, register map, state encoding and fixed constants.
// ============================================================================
package spps_pkg;

    // Field widths
    localparam int SPEED_W   = 11;
    localparam int THICK_W   = 13;
    localparam int FRAC_BITS = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Shared divider datapath
    localparam int ACC_W = 36;
    localparam int Q_W   = 8;
    localparam int CNT_W = 3;
    localparam int F_W   = 14;

    // Hue constants in Q.8: full circle 360*256, one sector 60*256
    localparam int HUE_FULL   = 92160;
    localparam int HUE_SECTOR = 15360;
    localparam int HUE_STEP   = 15;

    // One hue sector spans 2**SECTOR_SHIFT plane positions; six sectors per circle
    localparam int HUE_SECTORS  = HUE_FULL / HUE_SECTOR;
    localparam int SECTOR_SHIFT = $clog2(HUE_SECTOR / HUE_STEP);

    // Lit when 20 * (T - D) > T, i.e. brightness above 0.05
    localparam int LIT_RATIO = 20;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_RESET = 11'd128;
    localparam logic [THICK_W-1:0] THICK_RESET = 13'd512;

    // Register indexes
    localparam logic [PADDR_W-3:0] REG_SCAN_SPEED = 1'b0;
    localparam logic [PADDR_W-3:0] REG_THICKNESS  = 1'b1;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Face codes
    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_BACK   = 3'd1;
    localparam logic [2:0] FACE_LEFT   = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    // Scan axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Hue sectors (red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta)
    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [2:0] face;
        logic [2:0] col;
        logic [2:0] row;
    } spps_in_t;

    typedef struct packed {
        logic       lit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } spps_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HUE,
        ST_C_LOAD,
        ST_C_DIV,
        ST_X_LOAD,
        ST_X_DIV,
        ST_OUT
    } spps_state_t;

endpackage

>>> src/scan_plane_pixel_shader.sv
// Pixel beat: when lit, C is loaded and divided, then X, then the result is output;
// when unlit, straight to output. Tick beat: no result (position update, then hue
// sector and fraction). One beat at a time; s_ready is high only in idle, so a lit pixel
// holds off input through the shared restoring divider (one quotient bit per cycle).
// The output register lets the next beat enter while a result waits.
// aresetn is synchronous, active low: plane at 0, forward, x axis, registers at defaults.
// ============================================================================
// Scan plane pixel shader
// Shades LED cube pixels against a moving scan plane, iterating one shared
// compare-subtract unit for both color channel divisions.
// ============================================================================
module scan_plane_pixel_shader #(
    parameter int FACE_SIZE = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spps_pkg::PADDR_W-1:0]    paddr,
    input  logic [spps_pkg::PDATA_W-1:0]    pwdata,
    output logic [spps_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  spps_pkg::spps_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output spps_pkg::spps_out_t             m_data
);
    import spps_pkg::*;

    localparam int POS_LIMIT = 3 * FACE_SIZE * (2 ** FRAC_BITS);
    localparam int POS_W     = $clog2(POS_LIMIT + 1);
    localparam int SUM_W     = POS_W + 2;
    localparam int XY_W      = $clog2(FACE_SIZE);
    localparam int DIST_W    = $clog2(3 * FACE_SIZE + 1);
    localparam int CMP_W     = (POS_W > THICK_W) ? POS_W : THICK_W;
    localparam int N20_W     = THICK_W + 5;
    localparam int P255_W    = THICK_W + 8;
    localparam int PROD_W    = P255_W + F_W;

    localparam logic signed [SUM_W-1:0] LIMIT_S = SUM_W'(POS_LIMIT);
    localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(Q_W - 1);

    // State and registers
    spps_state_t            state_reg, state_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [THICK_W-1:0]     thick_reg, thick_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   back_reg, back_next;
    logic [1:0]             axis_reg, axis_next;
    logic [2:0]             sector_reg, sector_next;
    logic [F_W-1:0]         f_reg, f_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [ACC_W-1:0]       den_reg, den_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic [Q_W-1:0]         c_reg, c_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [THICK_W-1:0]     n_reg, n_next;
    logic                   lit_reg, lit_next;
    logic                   m_valid_reg, m_valid_next;
    spps_out_t              m_data_reg, m_data_next;

    // Combinational helpers
    logic                   s_fire;
    logic                   out_free;
    logic                   cfg_wr;
    logic [PADDR_W-3:0]     cfg_idx;
    logic signed [SUM_W-1:0] pos_ext, spd_ext, pos_sum;
    logic [XY_W-1:0]        xs, ys;
    logic [DIST_W-1:0]      pix_dist;
    logic [POS_W-1:0]       dist_q;
    logic signed [POS_W:0]  diff;
    logic [POS_W-1:0]       dabs;
    logic [CMP_W-1:0]       d_c, t_c;
    logic                   in_band;
    logic [THICK_W-1:0]     n_val;
    logic [N20_W-1:0]       n20;
    logic                   pix_lit;
    logic [POS_W-1:0]       hue_sec;
    logic [F_W-1:0]         hue_frac;
    logic [ACC_W:0]         sub;
    logic                   ge;
    logic                   div_last;
    logic [P255_W-1:0]      p255;
    logic [PROD_W-1:0]      prod;
    spps_out_t              result;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[PADDR_W-1:2];

    // Register read back
    always_comb begin
        case (cfg_idx)
            REG_SCAN_SPEED: prdata = PDATA_W'(speed_reg);
            REG_THICKNESS:  prdata = PDATA_W'(thick_reg);
            default:        prdata = '0;
        endcase
    end

    // Plane step: add or subtract speed; the tick clamps the sum at both ends
    always_comb begin
        pos_ext = signed'(SUM_W'(pos_reg));
        spd_ext = signed'(SUM_W'(speed_reg));
        pos_sum = back_reg ? (pos_ext - spd_ext) : (pos_ext + spd_ext);
    end

    // Saturate column and row to the face
    always_comb begin
        xs = (int'(s_data.col) > FACE_SIZE - 1) ? XY_W'(FACE_SIZE - 1) : XY_W'(s_data.col);
        ys = (int'(s_data.row) > FACE_SIZE - 1) ? XY_W'(FACE_SIZE - 1) : XY_W'(s_data.row);
    end

    // Map face and pixel to a distance along the unfolded cube
    always_comb begin
        pix_dist = '0;
        case (axis_reg)
            AXIS_X: begin
                case (s_data.face)
                    FACE_LEFT:   pix_dist = DIST_W'(xs);
                    FACE_FRONT:  pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(xs);
                    FACE_RIGHT:  pix_dist = DIST_W'(2 * FACE_SIZE) + DIST_W'(xs);
                    FACE_BACK:   pix_dist = DIST_W'(3 * FACE_SIZE) - DIST_W'(xs);
                    FACE_TOP:    pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(xs);
                    FACE_BOTTOM: pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(xs);
                    default:     pix_dist = '0;
                endcase
            end
            AXIS_Y: begin
                case (s_data.face)
                    FACE_BOTTOM: pix_dist = DIST_W'(ys);
                    FACE_FRONT:  pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(ys);
                    FACE_TOP:    pix_dist = DIST_W'(2 * FACE_SIZE) + DIST_W'(ys);
                    FACE_BACK:   pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(ys);
                    FACE_LEFT:   pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(ys);
                    FACE_RIGHT:  pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(ys);
                    default:     pix_dist = '0;
                endcase
            end
            default: begin
                // z axis; the unused axis code also lands here
                case (s_data.face)
                    FACE_BACK:   pix_dist = DIST_W'(ys);
                    FACE_TOP:    pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(ys);
                    FACE_FRONT:  pix_dist = DIST_W'(2 * FACE_SIZE) + DIST_W'(ys);
                    FACE_BOTTOM: pix_dist = DIST_W'(FACE_SIZE)
                                            + (DIST_W'(FACE_SIZE - 1) - DIST_W'(ys));
                    FACE_LEFT:   pix_dist = DIST_W'(FACE_SIZE) + DIST_W'(xs);
                    FACE_RIGHT:  pix_dist = DIST_W'(FACE_SIZE)
                                            + (DIST_W'(FACE_SIZE - 1) - DIST_W'(xs));
                    default:     pix_dist = '0;
                endcase
            end
        endcase
    end

    // Distance to plane and lit test
    always_comb begin
        dist_q  = POS_W'({pix_dist, {FRAC_BITS{1'b0}}});
        diff    = signed'({1'b0, dist_q}) - signed'({1'b0, pos_reg});
        dabs    = diff[POS_W] ? POS_W'(-diff) : POS_W'(diff);
        d_c     = CMP_W'(dabs);
        t_c     = CMP_W'(thick_reg);
        in_band = (d_c < t_c);
        n_val   = THICK_W'(t_c - d_c);
        n20     = N20_W'(n_val) * N20_W'(LIT_RATIO);
        pix_lit = in_band && (n20 > N20_W'(thick_reg));
    end

    // Hue from the plane position: position * 15 over one sector is position >> 10,
    // so the sector wraps by compare-subtract and the fraction is 15 * low bits
    always_comb begin
        hue_sec = pos_reg >> SECTOR_SHIFT;
        if (hue_sec >= POS_W'(2 * HUE_SECTORS)) begin
            hue_sec = hue_sec - POS_W'(2 * HUE_SECTORS);
        end
        if (hue_sec >= POS_W'(HUE_SECTORS)) begin
            hue_sec = hue_sec - POS_W'(HUE_SECTORS);
        end
        hue_frac = F_W'(pos_reg[SECTOR_SHIFT-1:0]) * F_W'(HUE_STEP);
    end

    // Shared compare-subtract unit
    always_comb begin
        sub      = {1'b0, acc_reg} - {1'b0, den_reg};
        ge       = !sub[ACC_W];
        div_last = (cnt_reg == CNT_LAST);
        p255     = {n_reg, {FRAC_BITS{1'b0}}} - P255_W'(n_reg);
        prod     = {{F_W{1'b0}}, p255} * {{P255_W{1'b0}}, f_reg};
    end

    // Assemble the colored pixel from C, X and the sector
    always_comb begin
        result     = '0;
        result.lit = lit_reg;
        if (lit_reg) begin
            case (sector_reg)
                SEC_RY: begin result.red   = c_reg; result.green = q_reg; end
                SEC_YG: begin result.red   = q_reg; result.green = c_reg; end
                SEC_GC: begin result.green = c_reg; result.blue  = q_reg; end
                SEC_CB: begin result.green = q_reg; result.blue  = c_reg; end
                SEC_BM: begin result.red   = q_reg; result.blue  = c_reg; end
                default: begin result.red  = c_reg; result.blue  = q_reg; end
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.kind == KIND_TICK) begin
                        state_next = ST_HUE;
                    end else if (pix_lit) begin
                        state_next = ST_C_LOAD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_HUE:      state_next = ST_IDLE;
            ST_C_LOAD:   state_next = ST_C_DIV;
            ST_C_DIV:    state_next = div_last ? ST_X_LOAD : ST_C_DIV;
            ST_X_LOAD:   state_next = ST_X_DIV;
            ST_X_DIV:    state_next = div_last ? ST_OUT : ST_X_DIV;
            ST_OUT:      state_next = out_free ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath controls per state
    always_comb begin
        speed_next   = speed_reg;
        thick_next   = thick_reg;
        pos_next     = pos_reg;
        back_next    = back_reg;
        axis_next    = axis_reg;
        sector_next  = sector_reg;
        f_next       = f_reg;
        acc_next     = acc_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        c_next       = c_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        lit_next     = lit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        // Configuration writes
        if (cfg_wr) begin
            case (cfg_idx)
                REG_SCAN_SPEED: speed_next = pwdata[SPEED_W-1:0];
                REG_THICKNESS:  thick_next = pwdata[THICK_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.kind == KIND_TICK) begin
                        // Advance plane; reverse and rotate axis at the far end, go forward at zero
                        if (pos_sum >= LIMIT_S) begin
                            pos_next  = POS_W'(POS_LIMIT);
                            back_next = 1'b1;
                            case (axis_reg)
                                AXIS_X:  axis_next = AXIS_Y;
                                AXIS_Y:  axis_next = AXIS_Z;
                                AXIS_Z:  axis_next = AXIS_X;
                                default: axis_next = AXIS_Y;
                            endcase
                        end else if (pos_sum[SUM_W-1] || pos_sum == '0) begin
                            pos_next  = '0;
                            back_next = 1'b0;
                        end else begin
                            pos_next = POS_W'(pos_sum);
                        end
                    end else begin
                        n_next   = n_val;
                        lit_next = pix_lit;
                    end
                end
            end
            ST_HUE: begin
                // Mirror the fraction in odd sectors
                sector_next = hue_sec[2:0];
                f_next      = hue_sec[0] ? (F_W'(HUE_SECTOR) - hue_frac) : hue_frac;
            end
            ST_C_LOAD: begin
                acc_next = ACC_W'(p255);
                den_next = ACC_W'(thick_reg) << (Q_W - 1);
                cnt_next = '0;
            end
            ST_X_LOAD: begin
                c_next   = q_reg;
                acc_next = ACC_W'(prod);
                den_next = (ACC_W'(thick_reg) * ACC_W'(HUE_SECTOR)) << (Q_W - 1);
                cnt_next = '0;
            end
            ST_C_DIV, ST_X_DIV: begin
                // One restoring step: subtract if it fits, shift divisor down
                if (ge) begin
                    acc_next = sub[ACC_W-1:0];
                end
                q_next   = {q_reg[Q_W-2:0], ge};
                den_next = den_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            speed_reg   <= SPEED_RESET;
            thick_reg   <= THICK_RESET;
            pos_reg     <= '0;
            back_reg    <= 1'b0;
            axis_reg    <= AXIS_X;
            sector_reg  <= SEC_RY;
            f_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            speed_reg   <= speed_next;
            thick_reg   <= thick_next;
            pos_reg     <= pos_next;
            back_reg    <= back_next;
            axis_reg    <= axis_next;
            sector_reg  <= sector_next;
            f_reg       <= f_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        q_reg      <= q_next;
        c_reg      <= c_next;
        cnt_reg    <= cnt_next;
        n_reg      <= n_next;
        lit_reg    <= lit_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> src/spps_checker.sv
// ============================================================================
// Scan plane pixel shader checker
// Port-level properties of the shader, bound to the top level.
// ============================================================================
`include "scan_plane_pixel_shader_defines.svh"

module spps_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input spps_pkg::spps_out_t  m_data,
    input logic                 pready
);
    import spps_pkg::*;

    // Hold a stalled result beat
    `SPPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // Drop color on unlit pixels
    `SPPS_ASSERT_NOW(a_unlit_black, aclk, aresetn, m_valid && !m_data.lit, m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0, "unlit pixel has color")

    // A lit pixel is above 0.05 brightness so its chroma channel is nonzero
    `SPPS_ASSERT_NOW(a_lit_colored, aclk, aresetn, m_valid && m_data.lit, (m_data.red | m_data.green | m_data.blue) != 8'd0, "lit pixel is black")

    // Busy in the cycle after any accepted beat
    `SPPS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready && pready, "ready right after an accepted beat")

endmodule

bind scan_plane_pixel_shader spps_checker u_spps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

>>> tb/scan_plane_pixel_shader_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Scan plane pixel shader testbench
// Sweeps the scan plane through all three axes under several speed and
// thickness settings. Predicts every pixel color from a local model of the
// plane and checks each result beat field by field, with random idling on
// both channels.
// ============================================================================
module scan_plane_pixel_shader_test;
    import spps_pkg::*;

    localparam int FACE_SIZE      = 8;
    localparam int POS_LIMIT      = 3 * FACE_SIZE * 256;
    localparam int CHANNEL_MAX    = 255;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 205;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    spps_in_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    spps_out_t            m_data;

    // Local copy of the shader state and registers
    int                   plane_q8       = 0;
    bit                   plane_reversed = 1'b0;
    logic [1:0]           sweep_axis     = AXIS_X;
    logic [SPEED_W-1:0]   speed_q8       = SPEED_RESET;
    logic [THICK_W-1:0]   thickness_q8   = THICK_RESET;

    spps_in_t             cube_beats[$];
    spps_out_t            expected_colors[$];
    int                   sender_idle_pct    = 0;
    int                   receiver_stall_pct = 0;
    int                   mismatch_count     = 0;
    int                   stall_cycles       = 0;

    scan_plane_pixel_shader #(
        .FACE_SIZE(FACE_SIZE)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Map a pixel to its whole-unit distance along the unfolded cube
    function automatic int unfold_distance(logic [2:0] face, logic [2:0] col,
                                           logic [2:0] row);
        int x;
        int y;
        int units;
        x = col;
        y = row;
        if (x > FACE_SIZE - 1) x = FACE_SIZE - 1;
        if (y > FACE_SIZE - 1) y = FACE_SIZE - 1;
        units = 0;
        case (sweep_axis)
            AXIS_X: begin
                case (face)
                    FACE_LEFT:              units = x;
                    FACE_FRONT:             units = FACE_SIZE + x;
                    FACE_RIGHT:             units = 2 * FACE_SIZE + x;
                    FACE_BACK:              units = 3 * FACE_SIZE - x;
                    FACE_TOP, FACE_BOTTOM:  units = FACE_SIZE + x;
                    default:                units = 0;
                endcase
            end
            AXIS_Y: begin
                case (face)
                    FACE_BOTTOM:                      units = y;
                    FACE_FRONT:                       units = FACE_SIZE + y;
                    FACE_TOP:                         units = 2 * FACE_SIZE + y;
                    FACE_BACK, FACE_LEFT, FACE_RIGHT: units = FACE_SIZE + y;
                    default:                          units = 0;
                endcase
            end
            // z axis, and the unused axis code alike
            default: begin
                case (face)
                    FACE_BACK:   units = y;
                    FACE_TOP:    units = FACE_SIZE + y;
                    FACE_FRONT:  units = 2 * FACE_SIZE + y;
                    FACE_BOTTOM: units = FACE_SIZE + (FACE_SIZE - 1 - y);
                    FACE_LEFT:   units = FACE_SIZE + x;
                    FACE_RIGHT:  units = FACE_SIZE + (FACE_SIZE - 1 - x);
                    default:     units = 0;
                endcase
            end
        endcase
        return units;
    endfunction

    // Move the plane one tick; clamp and turn at either end
    function automatic void advance_plane();
        int p;
        p = plane_reversed ? plane_q8 - int'(speed_q8) : plane_q8 + int'(speed_q8);
        if (p >= POS_LIMIT) begin
            p = POS_LIMIT;
            plane_reversed = 1'b1;
            sweep_axis = (sweep_axis == AXIS_Z) ? AXIS_X : sweep_axis + 2'd1;
        end else if (p <= 0) begin
            p = 0;
            plane_reversed = 1'b0;
        end
        plane_q8 = p;
    endfunction

    // Work out the color of one pixel against the current plane
    function automatic spps_out_t predict_color(spps_in_t px);
        spps_out_t color;
        longint    gap;
        longint    span;
        longint    hue;
        longint    sector;
        longint    frac;
        longint    full;
        longint    part;
        color = '0;
        gap = longint'(unfold_distance(px.face, px.col, px.row)) * 256 - plane_q8;
        if (gap < 0) gap = -gap;
        span = thickness_q8;
        if (gap >= span || LIT_RATIO * (span - gap) <= span) return color;
        hue    = (longint'(plane_q8) * HUE_STEP) % HUE_FULL;
        sector = hue / HUE_SECTOR;
        frac   = hue % HUE_SECTOR;
        if (sector[0]) frac = HUE_SECTOR - frac;
        full = (CHANNEL_MAX * (span - gap)) / span;
        part = (CHANNEL_MAX * (span - gap) * frac) / (span * HUE_SECTOR);
        color.lit = 1'b1;
        case (sector[2:0])
            SEC_RY: begin
                color.red   = full[7:0];
                color.green = part[7:0];
            end
            SEC_YG: begin
                color.red   = part[7:0];
                color.green = full[7:0];
            end
            SEC_GC: begin
                color.green = full[7:0];
                color.blue  = part[7:0];
            end
            SEC_CB: begin
                color.green = part[7:0];
                color.blue  = full[7:0];
            end
            SEC_BM: begin
                color.red   = part[7:0];
                color.blue  = full[7:0];
            end
            default: begin
                color.red   = full[7:0];
                color.blue  = part[7:0];
            end
        endcase
        return color;
    endfunction

    // Drive input beats from the pending queue; hold each until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (cube_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= cube_beats.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check result beats first, then update the prediction for accepted input
    always @(posedge aclk) begin
        spps_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("unexpected result beat: lit=%0d rgb=%0d,%0d,%0d",
                           m_data.lit, m_data.red, m_data.green, m_data.blue);
                    mismatch_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_data.lit !== want.lit) begin
                        $error("lit: expected %0d, got %0d", want.lit, m_data.lit);
                        mismatch_count++;
                    end
                    if (m_data.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, m_data.red);
                        mismatch_count++;
                    end
                    if (m_data.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, m_data.green);
                        mismatch_count++;
                    end
                    if (m_data.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, m_data.blue);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.kind == KIND_TICK) advance_plane();
                else expected_colors.push_back(predict_color(s_data));
            end
        end
    end

    // Abort when work is outstanding but no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cube_beats.size() == 0 && !s_valid && expected_colors.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_beat(input logic kind, input logic [2:0] face,
                             input logic [2:0] col, input logic [2:0] row);
        spps_in_t beat;
        beat.kind = kind;
        beat.face = face;
        beat.col  = col;
        beat.row  = row;
        cube_beats.push_back(beat);
    endtask

    // Mostly real faces, some unused face codes; ticks carry random filler
    task automatic push_random_beat();
        logic [2:0] face;
        logic       kind;
        face = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        kind = ($urandom_range(3) == 0) ? KIND_TICK : KIND_PIXEL;
        push_beat(kind, face, 3'($urandom_range(7)), 3'($urandom_range(7)));
    endtask

    // Write a register, then read it back
    task automatic write_register(input logic [PADDR_W-3:0] index,
                                  input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] stored;
        logic [PDATA_W-1:0] readback;
        stored = '0;
        if (index == REG_SCAN_SPEED) begin
            stored[SPEED_W-1:0] = value[SPEED_W-1:0];
            speed_q8 = value[SPEED_W-1:0];
        end else begin
            stored[THICK_W-1:0] = value[THICK_W-1:0];
            thickness_q8 = value[THICK_W-1:0];
        end
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored) begin
            $error("prdata: expected %0d, got %0d", stored, readback);
            mismatch_count++;
        end
    endtask

    // Wait until every beat is taken and every result is back, then let a
    // trailing tick finish before the registers change
    task automatic wait_drained();
        do @(negedge aclk);
        while (cube_beats.size() != 0 || s_valid || expected_colors.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int speed;
        int thick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: plane at zero on the x axis, every face and unused codes
        push_beat(KIND_PIXEL, FACE_LEFT, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_LEFT, 3'd1, 3'd7);
        push_beat(KIND_PIXEL, 3'd6, 3'd7, 3'd7);
        push_beat(KIND_PIXEL, 3'd7, 3'd0, 3'd7);
        push_beat(KIND_PIXEL, FACE_FRONT, 3'd7, 3'd0);
        push_beat(KIND_PIXEL, FACE_BACK, 3'd7, 3'd7);
        push_beat(KIND_TICK, 3'd7, 3'd7, 3'd7);
        push_beat(KIND_PIXEL, FACE_LEFT, 3'd0, 3'd5);
        push_beat(KIND_TICK, FACE_FRONT, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_TOP, 3'd1, 3'd3);
        push_beat(KIND_PIXEL, FACE_BOTTOM, 3'd0, 3'd7);
        push_beat(KIND_PIXEL, FACE_RIGHT, 3'd0, 3'd0);
        wait_drained();

        // Fastest, widest plane: run into the far end and turn onto the y axis
        write_register(REG_SCAN_SPEED, 32'd1536);
        write_register(REG_THICKNESS, 32'd6144);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_FRONT, 3'd3, 3'd4);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_TOP, 3'd0, 3'd7);
        push_beat(KIND_PIXEL, FACE_BOTTOM, 3'd7, 3'd0);
        wait_drained();

        // Zero speed clamped at the far end: each tick moves to the next axis
        write_register(REG_SCAN_SPEED, 32'd0);
        write_register(REG_THICKNESS, 32'd1);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_FRONT, 3'd0, 3'd7);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_BACK, 3'd0, 3'd0);
        push_beat(KIND_TICK, 3'd0, 3'd0, 3'd0);
        wait_drained();

        // Zero thickness: nothing lights
        write_register(REG_THICKNESS, 32'd0);
        push_beat(KIND_PIXEL, FACE_BACK, 3'd0, 3'd0);
        push_beat(KIND_PIXEL, FACE_TOP, 3'd7, 3'd7);
        wait_drained();

        // Random phases over a spread of settings and idling patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin speed = 128;                         thick = 512;                         end
                1: begin speed = 1536;                        thick = 6144;                        end
                2: begin speed = 1;                           thick = 1;                           end
                3: begin speed = $urandom_range(1536, 1);     thick = $urandom_range(6144, 1);     end
                4: begin speed = 0;                           thick = $urandom_range(6144, 256);   end
                5: begin speed = $urandom_range(1536, 600);   thick = $urandom_range(256, 1);      end
                6: begin speed = $urandom_range(300, 1);      thick = $urandom_range(6144, 2000);  end
                default: begin
                    speed = $urandom_range(1536);
                    thick = $urandom_range(6144, 1);
                end
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            write_register(REG_SCAN_SPEED, speed);
            write_register(REG_THICKNESS, thick);
            repeat (PHASE_BEATS) push_random_beat();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/spps_pkg.sv
src/scan_plane_pixel_shader.sv
src/spps_checker.sv
tb/scan_plane_pixel_shader_test.sv
